// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module ips_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`endif

// File: hw/rtl/ips_pkg.sv
// Package for the index permutation shuffler: command codes, field widths,
// and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package ips_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int CMD_BITS   = 2;
	localparam int VAL_BITS   = 32;
	localparam int RND_BITS   = 64;
	localparam int POS_BITS   = 10;
	localparam int HELD_BITS  = 11;

	localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_APPEND  = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd2;

endpackage

// File: hw/rtl/ips_mod_unit.sv
// Radix-2 restoring modulo unit: 64-bit dividend by a small divisor,
// one bit per cycle. Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_mod_unit #(
	parameter int DW = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ips_pkg::RND_BITS-1:0] dividend,
	input  logic [DW-1:0]                divisor,
	output logic                         done,
	output logic [DW-1:0]                remainder
);
	import ips_pkg::*;

	localparam int CNTW = $clog2(RND_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CNTW-1:0]     cnt_q;
	logic [RND_BITS-1:0] dq_q;
	logic [DW-1:0]       div_q;
	logic [DW-1:0]       rem_q;
	logic [DW:0]         shifted;
	logic [DW:0]         diff;
	logic [DW-1:0]       rem_next;

	assign shifted  = {rem_q, dq_q[RND_BITS-1]};
	assign diff     = shifted - {1'b0, div_q};
	assign rem_next = (shifted >= {1'b0, div_q}) ? diff[DW-1:0] : shifted[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(RND_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[RND_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/ips_store.sv
// Single-port element store with registered read data.
// Depends on ips_pkg.
`timescale 1ns / 1ps

module ips_store #(
	parameter int DEPTH      = ips_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = ips_pkg::VALUE_BITS_DEF,
	parameter int AW         = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic                  re,
	input  logic [AW-1:0]         addr,
	input  logic [VALUE_BITS-1:0] wdata,
	output logic [VALUE_BITS-1:0] rdata
);
	import ips_pkg::*;

	logic [VALUE_BITS-1:0] mem [DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/index_permutation_shuffler_unit.sv
// Accept to result valid: append runs the 64-step modulo unit, reads the element at
// the remainder j, copies it to slot count, then writes the value at j, one write per
// step on the single store port; read reads the store; restart and rejects go straight to ST_FIN.
// A finished result may wait in the output register while the next beat is taken.
// Reset (arst_n, async low) clears the count and control; store contents stay
// undefined and need no clearing pass.
`timescale 1ns / 1ps

module index_permutation_shuffler_unit #(
	parameter int DEPTH      = ips_pkg::DEPTH_DEF,
	parameter int VALUE_BITS = ips_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ips_pkg::CMD_BITS-1:0]  cmd,
	input  logic [ips_pkg::VAL_BITS-1:0]  value,
	input  logic [ips_pkg::RND_BITS-1:0]  random_word,
	input  logic [ips_pkg::POS_BITS-1:0]  position,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ips_pkg::VAL_BITS-1:0]  read_value,
	output logic [ips_pkg::HELD_BITS-1:0] entries_held,
	output logic                          error
);
	import ips_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_WRN,
		ST_WRJ,
		ST_RDP,
		ST_FIN
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         j_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [VAL_BITS-1:0]   res_rd_q;
	logic                  res_err_q;
	logic                  out_valid_q;
	logic [VAL_BITS-1:0]   read_value_q;
	logic [HELD_BITS-1:0]  entries_held_q;
	logic                  error_q;

	logic                  accept;
	logic                  full;
	logic                  pos_bad;
	logic                  res_load;
	logic                  mod_start;
	logic                  mod_done;
	logic [CW-1:0]         mod_rem;
	logic                  mem_we;
	logic                  mem_re;
	logic [AW-1:0]         mem_addr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic [VALUE_BITS-1:0] mem_rdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign full      = (count_q == CW'(DEPTH));
	assign pos_bad   = (CMPW'(position) >= CMPW'(count_q));
	assign res_load  = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign mod_start = accept && (cmd == CMD_APPEND) && !full;

	ips_mod_unit #(
		.DW(CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (random_word),
		.divisor   (count_q + 1'b1),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = count_q[AW-1:0];
		mem_wdata = mem_rdata;
		unique case (state_q)
			ST_IDLE: begin
				mem_re   = accept && (cmd == CMD_READ) && !pos_bad;
				mem_addr = AW'(position);
			end
			ST_MOD: begin
				mem_re   = mod_done;
				mem_addr = mod_rem[AW-1:0];
			end
			ST_WRN: begin
				mem_we    = 1'b1;
				mem_addr  = count_q[AW-1:0];
				mem_wdata = mem_rdata;
			end
			ST_WRJ: begin
				mem_we    = 1'b1;
				mem_addr  = j_q;
				mem_wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	ips_store #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						val_q     <= VALUE_BITS'(value);
						res_rd_q  <= '0;
						res_err_q <= 1'b0;
						state_q   <= ST_FIN;
						unique case (cmd)
							CMD_RESTART: count_q <= '0;
							CMD_APPEND: begin
								if (full) begin
									res_err_q <= 1'b1;
								end else begin
									state_q <= ST_MOD;
								end
							end
							CMD_READ: begin
								if (pos_bad) begin
									res_err_q <= 1'b1;
								end else begin
									state_q <= ST_RDP;
								end
							end
							default: res_err_q <= 1'b1;
						endcase
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						j_q     <= mod_rem[AW-1:0];
						state_q <= ST_WRN;
					end
				end
				ST_WRN: state_q <= ST_WRJ;
				ST_WRJ: begin
					count_q <= count_q + 1'b1;
					state_q <= ST_FIN;
				end
				ST_RDP: begin
					res_rd_q <= VAL_BITS'(mem_rdata);
					state_q  <= ST_FIN;
				end
				ST_FIN: begin
					if (res_load) begin
						read_value_q   <= res_rd_q;
						entries_held_q <= HELD_BITS'(count_q);
						error_q        <= res_err_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign read_value   = read_value_q;
	assign entries_held = entries_held_q;
	assign error        = error_q;

endmodule

// File: hw/rtl/ips_checker.sv
// Port-level checker for index_permutation_shuffler_unit, with its bind.
// Depends on ips_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ips_checker #(
	parameter int DEPTH = ips_pkg::DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ips_pkg::VAL_BITS-1:0]  read_value,
	input logic [ips_pkg::HELD_BITS-1:0] entries_held,
	input logic                          error
);
	import ips_pkg::*;

	// block is not ready in the cycle after taking a beat
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, (in_valid && in_ready) |=> !in_ready)

	// a rejected beat never carries data
	`ASSERT_NEVER(a_err_no_data, clk, arst_n, out_valid && error && (read_value != '0))

	// count shown stays within the store size
	`ASSERT_NEVER(a_held_range, clk, arst_n,
		out_valid && (32'(entries_held) > 32'(DEPTH)) && (DEPTH < (1 << HELD_BITS)))

	// a stalled result holds
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		(out_valid && !out_ready) |=> (out_valid && $stable(read_value)
			&& $stable(entries_held) && $stable(error)))

endmodule

bind index_permutation_shuffler_unit ips_checker #(
	.DEPTH (DEPTH)
) u_ips_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_value   (read_value),
	.entries_held (entries_held),
	.error        (error)
);
